FILE: rtl/xte_pkg.sv
// ============================================================================
// xte_pkg
// Shared types and constants of the XML text escaper.
// ============================================================================
package xte_pkg;

  localparam int CP_W         = 21;  // code point width
  localparam int LEN_W        = 4;   // byte count of one escaped item (1..10)
  localparam int CFG_AW       = 4;   // APB address width, registers at 4*i
  localparam int CFG_DW       = 32;
  localparam int FIFO_DEPTH_D = 2;   // default descriptor queue depth

  // Register indexes
  localparam logic [1:0] REG_QUOTE_MODE = 2'd0;
  localparam logic [1:0] REG_ESC_ALL    = 2'd1;
  localparam logic [1:0] REG_UNI_HEX    = 2'd2;

  // Quote mode codes
  localparam logic [1:0] QM_ELEMENT = 2'd0;
  localparam logic [1:0] QM_DOUBLE  = 2'd1;
  localparam logic [1:0] QM_SINGLE  = 2'd2;

  typedef enum logic [1:0] {
    K_BYTE = 2'd0,  // one literal byte
    K_ENT  = 2'd1,  // named entity
    K_HEX  = 2'd2,  // hexadecimal character reference
    K_UTF8 = 2'd3   // plain UTF-8 encoding
  } xte_kind_t;

  typedef enum logic [2:0] {
    E_AMP  = 3'd0,
    E_LT   = 3'd1,
    E_GT   = 3'd2,
    E_QUOT = 3'd3,
    E_APOS = 3'd4
  } xte_ent_t;

  typedef struct packed {
    logic [1:0] quote_mode;
    logic       esc_all;   // escape '>' and both quotes always
    logic       uni_hex;   // non-ASCII as hex character references
  } xte_cfg_t;

  // Classified item handed from the front to the back
  typedef struct packed {
    xte_kind_t         kind;
    xte_ent_t          ent;
    logic [LEN_W-1:0]  len;
    logic [CP_W-1:0]   val;
  } xte_desc_t;

endpackage

FILE: rtl/xte_if.sv
// ============================================================================
// xte_if
// Valid/ready channels of the XML text escaper.
// ============================================================================
interface xte_in_if;
  logic                        valid;
  logic                        ready;
  logic [xte_pkg::CP_W-1:0]    code_point;

  modport source (output valid, output code_point, input ready);
  modport sink   (input valid, input code_point, output ready);
endinterface

interface xte_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

FILE: rtl/xml_text_escaper.sv
// ============================================================================
// xml_text_escaper
// XML escaping of Unicode code points into UTF-8 bytes with an APB config port.
// ============================================================================
// Path: an accepted item passes the front register, the queue and the
//   expander/output register before its first byte is valid on out_ch.
// Throughput: one output byte per cycle while out_ch is ready, set by the
//   single byte-wide output register; an item gives its 1 to 10 escaped bytes.
// Reset (rst_n low, synchronous): clears the config registers to 0 and all
//   valid flags; no item or byte is held afterwards.

module xml_text_escaper #(
  parameter int FIFO_DEPTH = xte_pkg::FIFO_DEPTH_D
) (
  input  logic                        clk,
  input  logic                        rst_n,
  xte_in_if.sink                      in_ch,
  xte_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [xte_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [xte_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [xte_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  // --------------------------------------------------------------------------
  // Config registers
  // --------------------------------------------------------------------------
  logic [1:0] quote_mode_r, quote_mode_nxt;
  logic       esc_all_r, esc_all_nxt;
  logic       uni_hex_r, uni_hex_nxt;
  logic       cfg_wr;
  logic [1:0] cfg_idx;
  xte_pkg::xte_cfg_t cfg;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  // Decode the write; an index past the last register is dropped.
  always_comb begin
    quote_mode_nxt = quote_mode_r;
    esc_all_nxt    = esc_all_r;
    uni_hex_nxt    = uni_hex_r;
    if (cfg_wr) begin
      case (cfg_idx)
        xte_pkg::REG_QUOTE_MODE: quote_mode_nxt = cfg_pwdata[1:0];
        xte_pkg::REG_ESC_ALL:    esc_all_nxt    = cfg_pwdata[0];
        xte_pkg::REG_UNI_HEX:    uni_hex_nxt    = cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quote_mode_r <= 2'd0;
      esc_all_r    <= 1'b0;
      uni_hex_r    <= 1'b0;
    end else begin
      quote_mode_r <= quote_mode_nxt;
      esc_all_r    <= esc_all_nxt;
      uni_hex_r    <= uni_hex_nxt;
    end
  end

  // Read back the addressed register, zero elsewhere.
  always_comb begin
    case (cfg_idx)
      xte_pkg::REG_QUOTE_MODE: cfg_prdata = {30'd0, quote_mode_r};
      xte_pkg::REG_ESC_ALL:    cfg_prdata = {31'd0, esc_all_r};
      xte_pkg::REG_UNI_HEX:    cfg_prdata = {31'd0, uni_hex_r};
      default:                 cfg_prdata = '0;
    endcase
  end

  assign cfg = {quote_mode_r, esc_all_r, uni_hex_r};

  // --------------------------------------------------------------------------
  // Front: accept and classify each code point into a descriptor
  // --------------------------------------------------------------------------
  logic               push;
  logic               full;
  xte_pkg::xte_desc_t f_desc;

  xte_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_i  (cfg),
    .full_i (full),
    .push_o (push),
    .desc_o (f_desc)
  );

  // --------------------------------------------------------------------------
  // Queue: decouple classification from byte emission
  // --------------------------------------------------------------------------
  logic               pop;
  logic               q_valid;
  xte_pkg::xte_desc_t q_desc;

  xte_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .wdata_i (f_desc),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (q_desc)
  );

  // --------------------------------------------------------------------------
  // Back: expand each descriptor into bytes, advance on out_ch handshakes
  // --------------------------------------------------------------------------
  xte_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid_i (q_valid),
    .q_desc_i  (q_desc),
    .pop_o     (pop),
    .out_ch    (out_ch)
  );

endmodule

FILE: rtl/xte_front.sv
// ============================================================================
// xte_front
// Accepts code points, classifies them and registers a descriptor.
// ============================================================================
module xte_front (
  input  logic               clk,
  input  logic               rst_n,
  xte_in_if.sink             in_ch,
  input  xte_pkg::xte_cfg_t  cfg_i,
  input  logic               full_i,
  output logic               push_o,
  output xte_pkg::xte_desc_t desc_o
);

  logic               f_valid_r, f_valid_nxt;
  xte_pkg::xte_desc_t f_desc_r;
  xte_pkg::xte_desc_t cls;
  logic               attr;
  logic               accept;
  logic [xte_pkg::CP_W-1:0] cp;

  assign cp           = in_ch.code_point;
  assign push_o       = f_valid_r && !full_i;
  assign in_ch.ready  = !f_valid_r || !full_i;
  assign accept       = in_ch.valid && in_ch.ready;
  assign desc_o       = f_desc_r;
  assign attr         = (cfg_i.quote_mode == xte_pkg::QM_DOUBLE) ||
                        (cfg_i.quote_mode == xte_pkg::QM_SINGLE);

  always_comb begin
    cls      = '0;
    cls.kind = xte_pkg::K_UTF8;
    cls.ent  = xte_pkg::E_AMP;
    cls.val  = cp;
    if (cp < 21'h20) begin
      if (cp == 21'h09 || cp == 21'h0a || cp == 21'h0d) begin
        cls.kind = xte_pkg::K_BYTE;
        cls.len  = 4'd1;
        cls.val  = attr ? 21'h20 : cp;
      end else begin
        cls.kind = xte_pkg::K_HEX;
        cls.len  = 4'd6;   // two digits
      end
    end else if (cp == 21'h26) begin
      cls.kind = xte_pkg::K_ENT;
      cls.ent  = xte_pkg::E_AMP;
      cls.len  = 4'd5;
    end else if (cp == 21'h3c) begin
      cls.kind = xte_pkg::K_ENT;
      cls.ent  = xte_pkg::E_LT;
      cls.len  = 4'd4;
    end else if (cp == 21'h3e && cfg_i.esc_all) begin
      cls.kind = xte_pkg::K_ENT;
      cls.ent  = xte_pkg::E_GT;
      cls.len  = 4'd4;
    end else if (cp == 21'h22 &&
                 (cfg_i.quote_mode == xte_pkg::QM_DOUBLE || cfg_i.esc_all)) begin
      cls.kind = xte_pkg::K_ENT;
      cls.ent  = xte_pkg::E_QUOT;
      cls.len  = 4'd6;
    end else if (cp == 21'h27 &&
                 (cfg_i.quote_mode == xte_pkg::QM_SINGLE || cfg_i.esc_all)) begin
      cls.kind = xte_pkg::K_ENT;
      cls.ent  = xte_pkg::E_APOS;
      cls.len  = 4'd6;
    end else if (cp > 21'h7f && cfg_i.uni_hex) begin
      cls.kind = xte_pkg::K_HEX;
      // at least four digits, at most six
      if (cp[20])               cls.len = 4'd10;
      else if (|cp[19:16])      cls.len = 4'd9;
      else                      cls.len = 4'd8;
    end else begin
      if (cp < 21'h80)          cls.len = 4'd1;
      else if (cp < 21'h800)    cls.len = 4'd2;
      else if (cp < 21'h10000)  cls.len = 4'd3;
      else                      cls.len = 4'd4;
    end
  end

  always_comb begin
    f_valid_nxt = f_valid_r;
    if (accept)      f_valid_nxt = 1'b1;
    else if (push_o) f_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_desc_r <= cls;
    end
  end

endmodule

FILE: rtl/xte_fifo.sv
// ============================================================================
// xte_fifo
// Short descriptor queue between the front and the back.
// ============================================================================
module xte_fifo #(
  parameter int DEPTH = xte_pkg::FIFO_DEPTH_D
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_i,
  input  xte_pkg::xte_desc_t wdata_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output xte_pkg::xte_desc_t rdata_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);

  xte_pkg::xte_desc_t mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full_o  = (count_r == DEPTH_C);
  assign valid_o = (count_r != '0);
  assign rdata_o = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_i) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    if (pop_i)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    if (push_i && !pop_i)      count_nxt = count_r + 1'b1;
    else if (pop_i && !push_i) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= wdata_i;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("queue count above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

endmodule

FILE: rtl/xte_emit.sv
// ============================================================================
// xte_emit
// Expands one descriptor into its escaped bytes, one per cycle while out_ch is ready.
// ============================================================================
module xte_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid_i,
  input  xte_pkg::xte_desc_t q_desc_i,
  output logic               pop_o,
  xte_out_if.source          out_ch
);

  localparam logic [47:0] S_AMP  = {"&amp;", 8'h00};
  localparam logic [47:0] S_LT   = {"&lt;", 16'h0000};
  localparam logic [47:0] S_GT   = {"&gt;", 16'h0000};
  localparam logic [47:0] S_QUOT = "&quot;";
  localparam logic [47:0] S_APOS = "&apos;";
  localparam logic [47:0] S_HREF = {"&#x", 24'h000000};

  function automatic logic [7:0] pick(logic [47:0] s, logic [2:0] i);
    logic [7:0] b;
    case (i)
      3'd0:    b = s[47:40];
      3'd1:    b = s[39:32];
      3'd2:    b = s[31:24];
      3'd3:    b = s[23:16];
      3'd4:    b = s[15:8];
      3'd5:    b = s[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [47:0] ent_str(xte_pkg::xte_ent_t e);
    logic [47:0] s;
    case (e)
      xte_pkg::E_AMP:  s = S_AMP;
      xte_pkg::E_LT:   s = S_LT;
      xte_pkg::E_GT:   s = S_GT;
      xte_pkg::E_QUOT: s = S_QUOT;
      xte_pkg::E_APOS: s = S_APOS;
      default:         s = S_AMP;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] gen_byte(xte_pkg::xte_desc_t d, logic [3:0] idx);
    logic [7:0] b;
    logic [3:0] pos;
    logic [3:0] nib;
    logic [1:0] grp;
    logic [5:0] six;
    b   = 8'h00;
    pos = d.len - 4'd2 - idx;
    grp = 2'(d.len - 4'd1 - idx);
    case (pos[2:0])
      3'd0:    nib = d.val[3:0];
      3'd1:    nib = d.val[7:4];
      3'd2:    nib = d.val[11:8];
      3'd3:    nib = d.val[15:12];
      3'd4:    nib = d.val[19:16];
      3'd5:    nib = {3'b000, d.val[20]};
      default: nib = 4'h0;
    endcase
    case (grp)
      2'd0:    six = d.val[5:0];
      2'd1:    six = d.val[11:6];
      2'd2:    six = d.val[17:12];
      default: six = {3'b000, d.val[20:18]};
    endcase
    case (d.kind)
      xte_pkg::K_BYTE: b = d.val[7:0];
      xte_pkg::K_ENT:  b = pick(ent_str(d.ent), idx[2:0]);
      xte_pkg::K_HEX: begin
        if (idx < 4'd3)                b = pick(S_HREF, idx[2:0]);
        else if (idx == d.len - 4'd1)  b = 8'h3b;
        else if (nib < 4'd10)          b = 8'h30 + {4'h0, nib};
        else                           b = 8'h57 + {4'h0, nib};
      end
      xte_pkg::K_UTF8: begin
        if (idx != 4'd0) begin
          b = {2'b10, six};
        end else begin
          case (d.len)
            4'd1:    b = d.val[7:0];
            4'd2:    b = {3'b110, d.val[10:6]};
            4'd3:    b = {4'b1110, d.val[15:12]};
            default: b = {5'b11110, d.val[20:18]};
          endcase
        end
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  xte_pkg::xte_desc_t cur_r;
  logic               cur_v_r, cur_v_nxt;
  logic [3:0]         idx_r, idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_byte_r;
  logic               out_last_r;
  logic               out_adv;
  logic               is_last;
  logic               load;

  assign out_adv = !out_valid_r || out_ch.ready;
  assign is_last = (idx_r == cur_r.len - 4'd1);
  assign load    = q_valid_i && (!cur_v_r || (out_adv && is_last));
  assign pop_o   = load;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.last_byte = out_last_r;

  always_comb begin
    cur_v_nxt     = cur_v_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (out_adv) out_valid_nxt = cur_v_r;
    if (load) begin
      cur_v_nxt = 1'b1;
      idx_nxt   = 4'd0;
    end else if (out_adv && cur_v_r) begin
      if (is_last) cur_v_nxt = 1'b0;
      else         idx_nxt   = idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r     <= 1'b0;
      idx_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      cur_v_r     <= cur_v_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) cur_r <= q_desc_i;
    if (out_adv && cur_v_r) begin
      out_byte_r <= gen_byte(cur_r, idx_r);
      out_last_r <= is_last;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_v_r |-> (idx_r < cur_r.len))
    else $error("byte index past item length");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cur_v_r |-> (cur_r.len != 4'd0))
    else $error("empty descriptor in progress");

  a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_v_r && out_adv && is_last) |=> (out_valid_r && out_last_r))
    else $error("final byte not marked last");

endmodule
